// File: sv/bprt_pkg.sv
// bprt_pkg: shared types and constants of the bitmap row to page transpose block
// payload structs for the request and response channels, the block hand-off struct
// no dependencies
package bprt_pkg;

   localparam int BYTES_PER_ROW_DEF = 16;
   localparam int PAGE_COUNT_DEF    = 8;
   localparam int ROWS_PER_PAGE     = 8;
   localparam int BAND_ROWS         = ROWS_PER_PAGE - 1;

   typedef struct packed {
      logic [7:0] pixel_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [7:0] column_byte;
      logic       block_last;
      logic       frame_last;
   } rsp_type;

   // one 8x8 block, rows[k] is page row k with bit 7 the leftmost pixel
   typedef struct packed {
      logic [ROWS_PER_PAGE-1:0][7:0] rows;
      logic                          frame_last;
   } block_type;

endpackage

// File: sv/bprt_col_ser.sv
// bprt_col_ser: holds one 8x8 block and sends it out as eight column bytes
// left column first, bit 0 of each byte is the top row of the page
// depends on bprt_pkg
module bprt_col_ser
   import bprt_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      load_valid,
   output logic      load_ready,
   input  block_type load_block,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp_data
);

   block_type block_ff;
   logic      valid_ff, valid_in;
   logic [2:0] col_ff, col_in;
   logic       last_col;
   logic [7:0] column;

   assign last_col   = (col_ff == 3'd7);
   assign load_ready = !valid_ff || (last_col && rsp_ready);

   always_comb begin
      valid_in = valid_ff;
      col_in   = col_ff;
      if (load_valid && load_ready) begin
         valid_in = 1'b1;
         col_in   = 3'd0;
      end else if (valid_ff && rsp_ready) begin
         if (last_col) begin
            valid_in = 1'b0;
         end else begin
            col_in = col_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         col_ff   <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         col_ff   <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_valid && load_ready) begin
         block_ff <= load_block;
      end
   end

   // column c takes bit 7-c of every row
   always_comb begin
      for (int k = 0; k < ROWS_PER_PAGE; k++) begin
         column[k] = block_ff.rows[k][3'd7 - col_ff];
      end
   end

   assign rsp_valid            = valid_ff;
   assign rsp_data.column_byte = column;
   assign rsp_data.block_last  = last_col;
   assign rsp_data.frame_last  = last_col && block_ff.frame_last;

endmodule

// File: sv/bitmap_row_to_page_transpose.sv
// bitmap_row_to_page_transpose: top level, band store memory and position tracking
// depends on bprt_pkg and bprt_col_ser
//
// Takes a one-bit-per-pixel frame of PAGE_COUNT*8 rows by BYTES_PER_ROW bytes in
// row-major order (bit 7 leftmost) and returns it as display page bytes, one byte
// per pixel column with the top row of the page in bit 0. Bytes of rows 0..6 of a
// page are written into a band store of BYTES_PER_ROW entries and are taken every
// cycle; they give no result. A byte of row 7 reads its band entry into the read
// stage registers, and the completed 8x8 block then goes to a column serialiser
// that loads it into its block register and sends it out as eight column bytes. The
// serialiser sets the pace: once the read stage and the serialiser both hold a
// block, a row 7 byte is taken only when the serialiser takes the held block as
// it sends its last column byte, so receiver stalls hold row 7 bytes back too.
// frame_start puts the position back to row 0, byte 0 before its byte is taken;
// after the last byte of a frame the position wraps without it. Rows 0..6 of every
// band entry are rewritten before row 7 reads it, even after a restart mid-page.
module bitmap_row_to_page_transpose
   import bprt_pkg::*;
#(
   parameter int BYTES_PER_ROW = BYTES_PER_ROW_DEF,
   parameter int PAGE_COUNT    = PAGE_COUNT_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int FRAME_ROWS = PAGE_COUNT * ROWS_PER_PAGE;
   localparam int BW = (BYTES_PER_ROW > 1) ? $clog2(BYTES_PER_ROW) : 1;
   localparam int RW = $clog2(FRAME_ROWS);
   localparam logic [BW-1:0] LAST_BYTE = BW'(BYTES_PER_ROW - 1);
   localparam logic [RW-1:0] LAST_ROW  = RW'(FRAME_ROWS - 1);

   logic [BW-1:0] byte_ff, byte_in, cur_byte;
   logic [RW-1:0] row_ff, row_in, cur_row;
   logic          row7, req_xfer, wr_en, rd_en;

   logic          s1_valid_ff, s1_valid_in;
   logic [7:0]    s1_px_ff;
   logic          s1_last_ff;
   logic [BAND_ROWS-1:0][7:0] rd_data_ff;
   logic [BAND_ROWS-1:0][7:0] band_mem [BYTES_PER_ROW];

   logic      load_ready, s1_move;
   block_type load_block;

   // position as seen by this byte, frame_start applied first
   assign cur_byte = req_data.frame_start ? '0 : byte_ff;
   assign cur_row  = req_data.frame_start ? '0 : row_ff;
   assign row7     = (cur_row[2:0] == 3'(ROWS_PER_PAGE - 1));

   assign s1_move   = s1_valid_ff && load_ready;
   assign req_ready = !row7 || !s1_valid_ff || s1_move;
   assign req_xfer  = req_valid && req_ready;
   assign wr_en     = req_xfer && !row7;
   assign rd_en     = req_xfer && row7;

   always_comb begin
      byte_in = byte_ff;
      row_in  = row_ff;
      if (req_xfer) begin
         if (cur_byte == LAST_BYTE) begin
            byte_in = '0;
            row_in  = (cur_row == LAST_ROW) ? '0 : cur_row + 1'b1;
         end else begin
            byte_in = cur_byte + 1'b1;
            row_in  = cur_row;
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (rd_en) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff     <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         byte_ff     <= byte_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // band store: byte-lane write of rows 0..6, whole entry read on row 7
   always_ff @(posedge clock) begin
      if (wr_en) begin
         band_mem[cur_byte][cur_row[2:0]] <= req_data.pixel_byte;
      end
      if (rd_en) begin
         rd_data_ff <= band_mem[cur_byte];
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         s1_px_ff   <= req_data.pixel_byte;
         s1_last_ff <= (cur_row == LAST_ROW) && (cur_byte == LAST_BYTE);
      end
   end

   assign load_block.rows       = {s1_px_ff, rd_data_ff};
   assign load_block.frame_last = s1_last_ff;

   bprt_col_ser u_col_ser (
      .clock      (clock),
      .reset      (reset),
      .load_valid (s1_valid_ff),
      .load_ready (load_ready),
      .load_block (load_block),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   // a row 7 transfer never lands on a read stage that is still held
   assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (!s1_valid_ff || s1_move))
      else $error("row 7 transfer overwrote a held block");

   // a held read stage keeps its band data
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !load_ready) |=> (s1_valid_ff && $stable(rd_data_ff)))
      else $error("held band data changed");

   assert property (@(posedge clock) disable iff (reset)
      (byte_ff <= LAST_BYTE) && (row_ff <= LAST_ROW))
      else $error("position out of range");

   // a block read on a row other than the last carries no frame end flag
   assert property (@(posedge clock) disable iff (reset)
      rd_en && (cur_row != LAST_ROW) |=> !s1_last_ff)
      else $error("frame end flag on a block that is not the last");

endmodule

// File: tb/sv/tb_top.sv
// tb_top: self-checking testbench for bitmap_row_to_page_transpose
// depends on bprt_pkg and the block itself; predicts page column bytes and checks every transfer
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import bprt_pkg::*;

   localparam int COLS         = BYTES_PER_ROW_DEF;
   localparam int FRAME_ROWS   = PAGE_COUNT_DEF * ROWS_PER_PAGE;
   localparam int PAGE_BYTES   = COLS * ROWS_PER_PAGE;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 32;

   typedef enum logic [1:0] {READY_ALWAYS, READY_COIN, READY_MOSTLY, READY_BURSTY} ready_mode_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   bitmap_row_to_page_transpose #(
      .BYTES_PER_ROW(COLS),
      .PAGE_COUNT(PAGE_COUNT_DEF)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   req_type        pending_bytes[$];
   rsp_type        expected_columns[$];
   logic [7:0]     band_rows[COLS][BAND_ROWS];
   int unsigned    row_pos;
   int unsigned    byte_pos;
   logic           req_taken;
   int             send_gap;
   int             send_burst;
   ready_mode_type ready_mode;
   int unsigned    cycle_count;
   int             idle_cycles;
   int             fail_count;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // mirror of the block: band store of rows 0..6, transpose on row 7
   function automatic void predict_columns(input req_type item);
      logic [7:0]  col;
      logic        at_frame_end;
      int unsigned page_row;
      rsp_type     col_item;
      if (item.frame_start) begin
         row_pos  = 0;
         byte_pos = 0;
      end
      page_row = row_pos % ROWS_PER_PAGE;
      if (page_row < BAND_ROWS) begin
         band_rows[byte_pos][page_row] = item.pixel_byte;
      end else begin
         at_frame_end = (row_pos == FRAME_ROWS - 1) && (byte_pos == COLS - 1);
         // column c is bit 7-c of every row, top row lands in bit 0
         for (int c = 0; c < 8; c++) begin
            for (int k = 0; k < BAND_ROWS; k++) col[k] = band_rows[byte_pos][k][7 - c];
            col[7] = item.pixel_byte[7 - c];
            col_item.column_byte = col;
            col_item.block_last  = (c == 7);
            col_item.frame_last  = (c == 7) && at_frame_end;
            expected_columns.push_back(col_item);
         end
      end
      byte_pos++;
      if (byte_pos == COLS) begin
         byte_pos = 0;
         row_pos++;
         if (row_pos == FRAME_ROWS) row_pos = 0;
      end
   endfunction

   // queue bytes; patterned blocks hold extremes, an edge pixel, a checkerboard or a bit walk
   task automatic queue_bytes(input int count, input bit start, input bit patterned);
      req_type item;
      int      b;
      int      k;
      for (int i = 0; i < count; i++) begin
         b = i % COLS;
         k = (i / COLS) % ROWS_PER_PAGE;
         item.frame_start = start && (i == 0);
         if (!patterned) begin
            item.pixel_byte = 8'($urandom_range(0, 255));
         end else begin
            case (b)
               0: begin
                  item.pixel_byte = 8'h00;
               end
               1: begin
                  item.pixel_byte = 8'hFF;
               end
               2: begin
                  item.pixel_byte = 8'h80;
               end
               3: begin
                  item.pixel_byte = 8'h01;
               end
               4: begin
                  item.pixel_byte = (k % 2 == 0) ? 8'hAA : 8'h55;
               end
               default: begin
                  item.pixel_byte = 8'h80 >> ((b + k) % 8);
               end
            endcase
         end
         pending_bytes.push_back(item);
      end
   endtask

   // sender: bursts of random length with random gaps, inputs change on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0 || pending_bytes.size() == 0) begin
            req_valid <= 1'b0;
            if (send_gap > 0) send_gap--;
         end else begin
            req_data  <= pending_bytes.pop_front();
            req_valid <= 1'b1;
            if (send_burst > 0) begin
               send_burst--;
            end else begin
               send_burst = $urandom_range(1, 48);
               send_gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
      end
   end

   // receiver stalls on a pattern that is picked anew at random
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (cycle_count % 150 == 0) ready_mode = ready_mode_type'($urandom_range(0, 3));
         case (ready_mode)
            READY_ALWAYS: begin
               rsp_ready <= 1'b1;
            end
            READY_COIN: begin
               rsp_ready <= 1'($urandom_range(0, 1));
            end
            READY_MOSTLY: begin
               rsp_ready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
               rsp_ready <= (cycle_count % 16) < 10;
            end
         endcase
      end
   end

   // sample both channels at the rising edge
   always @(posedge clock) begin
      rsp_type want;
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) predict_columns(req_data);
         if (rsp_valid && rsp_ready) begin
            if (expected_columns.size() == 0) begin
               $error("unexpected transfer: column_byte %h block_last %b frame_last %b",
                      rsp_data.column_byte, rsp_data.block_last, rsp_data.frame_last);
               fail_count++;
            end else begin
               want = expected_columns.pop_front();
               if (rsp_data.column_byte !== want.column_byte) begin
                  $error("column_byte expected %h actual %h", want.column_byte,
                         rsp_data.column_byte);
                  fail_count++;
               end
               if (rsp_data.block_last !== want.block_last) begin
                  $error("block_last expected %b actual %b", want.block_last,
                         rsp_data.block_last);
                  fail_count++;
               end
               if (rsp_data.frame_last !== want.frame_last) begin
                  $error("frame_last expected %b actual %b", want.frame_last,
                         rsp_data.frame_last);
                  fail_count++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("bitmap_row_to_page_transpose test failed");
            $finish;
         end
      end
   end

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_ready   = 1'b0;
      req_taken   = 1'b0;
      row_pos     = 0;
      byte_pos    = 0;
      send_gap    = 0;
      send_burst  = 0;
      ready_mode  = READY_ALWAYS;
      cycle_count = 0;
      idle_cycles = 0;
      fail_count  = 0;

      // random page cut short part way into row 4, then a restart into a patterned page
      queue_bytes(4 * COLS + COLS / 2, 1'b1, 1'b0);
      queue_bytes(PAGE_BYTES, 1'b1, 1'b1);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() != 0 || req_valid) @(posedge clock);
      while (expected_columns.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("bitmap_row_to_page_transpose test passed");
      end else begin
         $display("bitmap_row_to_page_transpose test failed");
      end
      $finish;
   end

endmodule

// File: files.f
sv/bprt_pkg.sv
sv/bprt_col_ser.sv
sv/bitmap_row_to_page_transpose.sv
tb/sv/tb_top.sv
